// ===== design/ptc_pkg.sv =====
`timescale 1ns / 1ps

package ptc_pkg;

  // One raw sensor sample
  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  // One compensated result
  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               divide_by_zero;
  } out_item_t;

  // Unpacked calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP      = 2'd0;
  localparam logic [1:0] CFG_PRES_LOW  = 2'd1;
  localparam logic [1:0] CFG_PRES_MID  = 2'd2;
  localparam logic [1:0] CFG_PRES_LAST = 2'd3;

  // Formula constants
  localparam logic [63:0] OFFSET_FINE = 64'd128000;
  localparam logic [19:0] PRES_FULL_HI = 20'd0;      // 1048576 = 2^20, low 20 bits zero
  localparam logic [63:0] PRES_SCALE  = 64'd3125;
  localparam logic [31:0] ROUND_HALF  = 32'd128;

endpackage

// ===== design/ptc_front.sv =====
`timescale 1ns / 1ps

module ptc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptc_pkg::in_item_t in_data,
  output logic              q_valid,
  output ptc_pkg::in_item_t q_item,
  input  logic              q_take
);
  import ptc_pkg::*;

  // Two-entry sample queue toward the compute engine
  in_item_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_take && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ===== design/ptc_div.sv =====
`timescale 1ns / 1ps

module ptc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  // Signed 64-bit restoring divider, one quotient bit per cycle
  logic        busy_r, busy_nxt;
  logic        fix_r, fix_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mb_r, mb_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_sh, trial;

  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mb_nxt   = mb_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    q_nxt    = q_r;
    rem_sh   = {rem_r, quo_r[63]};
    trial    = rem_sh - {1'b0, mb_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      neg_nxt  = dividend[63] ^ divisor[63];
      quo_nxt  = dividend[63] ? (64'd0 - dividend) : dividend;
      mb_nxt   = divisor[63] ? (64'd0 - divisor) : divisor;
      rem_nxt  = 64'd0;
    end else if (busy_r) begin
      // remainder stays below the divisor magnitude, so 64 bits hold it
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      // sign correction; the overflow case wraps naturally
      q_nxt    = neg_r ? (64'd0 - quo_r) : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mb_r  <= mb_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    q_r   <= q_nxt;
  end

endmodule

// ===== design/ptc_back.sv =====
`timescale 1ns / 1ps

module ptc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ptc_pkg::coeff_t    coeff,
  input  logic               q_valid,
  input  ptc_pkg::in_item_t  q_item,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output ptc_pkg::out_item_t out_data
);
  import ptc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_POST = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Product steps of the compensation sequence
  localparam logic [3:0] K_A   = 4'd0;
  localparam logic [3:0] K_DD  = 4'd1;
  localparam logic [3:0] K_B   = 4'd2;
  localparam logic [3:0] K_SQ  = 4'd3;
  localparam logic [3:0] K_V2A = 4'd4;
  localparam logic [3:0] K_V2B = 4'd5;
  localparam logic [3:0] K_XA  = 4'd6;
  localparam logic [3:0] K_XB  = 4'd7;
  localparam logic [3:0] K_DEN = 4'd8;
  localparam logic [3:0] K_DVD = 4'd9;
  localparam logic [3:0] K_W1A = 4'd10;
  localparam logic [3:0] K_W1B = 4'd11;
  localparam logic [3:0] K_W2  = 4'd12;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] op_a_r, op_a_nxt, op_b_r, op_b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [19:0] adt_r, adt_nxt, adp_r, adp_nxt;
  logic [31:0] at_r, at_nxt, dd_r, dd_nxt, tf_r, tf_nxt, tc_r, tc_nxt;
  logic [63:0] v1_r, v1_nxt, sq_r, sq_nxt, v2_r, v2_nxt, x_r, x_nxt;
  logic [63:0] den_r, den_nxt, p_r, p_nxt, w_r, w_nxt;
  logic        dz_r, dz_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic        div_start, div_done;
  logic [63:0] div_q;

  // scratch
  logic [31:0] b32, tf32, tf5, tc32, d32;
  logic [63:0] v1c, x64, y64, num, ps, res;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Shared 32x32 multiplier: low 64 bits of a 64x64 product in three passes
  assign mul_x = (phase_r == 2'd2) ? op_a_r[63:32] : op_a_r[31:0];
  assign mul_y = (phase_r == 2'd1) ? op_b_r[63:32] : op_b_r[31:0];
  assign prod  = {32'd0, mul_x} * {32'd0, mul_y};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    acc_nxt       = acc_r;
    adt_nxt       = adt_r;
    adp_nxt       = adp_r;
    at_nxt        = at_r;
    dd_nxt        = dd_r;
    tf_nxt        = tf_r;
    tc_nxt        = tc_r;
    v1_nxt        = v1_r;
    sq_nxt        = sq_r;
    v2_nxt        = v2_r;
    x_nxt         = x_r;
    den_nxt       = den_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    q_take        = 1'b0;
    div_start     = 1'b0;
    b32  = 32'($signed(acc_r[31:0]) >>> 14);
    tf32 = at_r + b32;
    tf5  = {tf32[29:0], 2'b00} + tf32;
    tc32 = 32'($signed(tf5 + ROUND_HALF) >>> 8);
    v1c  = {{32{tf32[31]}}, tf32} - OFFSET_FINE;
    d32  = {16'd0, adt_r[19:4]} - {16'd0, coeff.t1};
    x64  = x_r + {acc_r[51:0], 12'd0};
    y64  = {17'd1, 47'd0} + x64;
    // ((2^20 - adp) << 31) - v2
    num  = {{12{1'b0}}, 1'b1, PRES_FULL_HI, 31'd0} - {13'd0, adp_r, 31'd0} - v2_r;
    ps   = 64'($signed(p_r) >>> 13);
    res  = 64'($signed(w_r) >>> 8) + {{44{coeff.p7[15]}}, coeff.p7, 4'd0};
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          adt_nxt   = q_item.raw_temperature;
          adp_nxt   = q_item.raw_pressure;
          dz_nxt    = 1'b0;
          op_a_nxt  = {32'd0, {15'd0, q_item.raw_temperature[19:3]}
                       - {15'd0, coeff.t1, 1'b0}};
          op_b_nxt  = sx16(coeff.t2);
          step_nxt  = K_A;
          phase_nxt = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        unique case (phase_r)
          2'd0:    acc_nxt = prod;
          default: acc_nxt = acc_r + {prod[31:0], 32'd0};
        endcase
        if (phase_r == 2'd2) begin
          state_nxt = ST_POST;
          phase_nxt = 2'd0;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      ST_POST: begin
        state_nxt = ST_MUL;
        step_nxt  = step_r + 4'd1;
        unique case (step_r)
          K_A: begin
            at_nxt   = 32'($signed(acc_r[31:0]) >>> 11);
            op_a_nxt = {32'd0, d32};
            op_b_nxt = {32'd0, d32};
          end
          K_DD: begin
            dd_nxt   = 32'($signed(acc_r[31:0]) >>> 12);
            op_a_nxt = {32'd0, dd_nxt};
            op_b_nxt = sx16(coeff.t3);
          end
          K_B: begin
            tf_nxt   = tf32;
            tc_nxt   = tc32;
            v1_nxt   = v1c;
            op_a_nxt = v1c;
            op_b_nxt = v1c;
          end
          K_SQ: begin
            sq_nxt   = acc_r;
            op_a_nxt = acc_r;
            op_b_nxt = sx16(coeff.p6);
          end
          K_V2A: begin
            v2_nxt   = acc_r;
            op_a_nxt = v1_r;
            op_b_nxt = sx16(coeff.p5);
          end
          K_V2B: begin
            v2_nxt   = v2_r + {acc_r[46:0], 17'd0}
                       + {{13{coeff.p4[15]}}, coeff.p4, 35'd0};
            op_a_nxt = sq_r;
            op_b_nxt = sx16(coeff.p3);
          end
          K_XA: begin
            x_nxt    = 64'($signed(acc_r) >>> 8);
            op_a_nxt = v1_r;
            op_b_nxt = sx16(coeff.p2);
          end
          K_XB: begin
            op_a_nxt = y64;
            op_b_nxt = {48'd0, coeff.p1};
          end
          K_DEN: begin
            den_nxt  = 64'($signed(acc_r) >>> 33);
            op_a_nxt = num;
            op_b_nxt = PRES_SCALE;
            if (den_nxt == 64'd0) begin
              // zero divisor: pressure forced to zero
              dz_nxt    = 1'b1;
              w_nxt     = 64'd0;
              state_nxt = ST_FIN;
            end
          end
          K_DVD: begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
          K_W1A: begin
            op_a_nxt = acc_r;
            op_b_nxt = ps;
          end
          K_W1B: begin
            w_nxt    = p_r + 64'($signed(acc_r) >>> 25);
            op_a_nxt = sx16(coeff.p8);
            op_b_nxt = p_r;
          end
          K_W2: begin
            w_nxt     = w_r + 64'($signed(acc_r) >>> 19);
            state_nxt = ST_FIN;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          p_nxt     = div_q;
          op_a_nxt  = sx16(coeff.p9);
          op_b_nxt  = 64'($signed(div_q) >>> 13);
          step_nxt  = K_W1A;
          phase_nxt = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_item_nxt.temperature_centi = tc_r;
          out_item_nxt.fine_temperature  = tf_r;
          out_item_nxt.pressure_q24_8    = dz_r ? 32'd0 : res[31:0];
          out_item_nxt.divide_by_zero    = dz_r;
          state_nxt                      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= K_A;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    acc_r      <= acc_nxt;
    adt_r      <= adt_nxt;
    adp_r      <= adp_nxt;
    at_r       <= at_nxt;
    dd_r       <= dd_nxt;
    tf_r       <= tf_nxt;
    tc_r       <= tc_nxt;
    v1_r       <= v1_nxt;
    sq_r       <= sq_nxt;
    v2_r       <= v2_nxt;
    x_r        <= x_nxt;
    den_r      <= den_nxt;
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    dz_r       <= dz_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.divide_by_zero |-> out_item_r.pressure_q24_8 == 32'd0)
    else $error("divide_by_zero result carries nonzero pressure");

  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> phase_r != 2'd3)
    else $error("multiplier phase out of range");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> state_r == ST_MUL && step_r == K_A)
    else $error("sample taken without starting sequence");
`endif

endmodule

// ===== design/pressure_temp_compensation_top.sv =====
`timescale 1ns / 1ps

// Barometric pressure and temperature compensation. Each input transaction
// carries raw 20-bit temperature and pressure readings and yields one result
// transaction with temperature in 0.01 degC, the fine temperature, pressure
// in Pa as unsigned Q24.8 and a divide-by-zero flag. Calibration words are
// written through the cfg_ port (index 0 T1..T3, 1 P1..P4, 2 P5..P8, 3 P9).
// The user must write calibration words only while the block is idle; the
// block itself does not enforce this. Each item uses thirteen 64-bit
// products on one shared 32x32 multiplier and a 64-bit divide at one
// quotient bit per cycle; when the divisor is zero the divide and the last
// products are skipped. A two-entry input queue and an output register let
// new samples and finished results move while the engine is busy.
module pressure_temp_compensation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ptc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import ptc_pkg::*;

  logic [47:0] temp_r;
  logic [63:0] plow_r, pmid_r;
  logic [15:0] plast_r;
  coeff_t      coeff;
  logic        q_valid, q_take;
  in_item_t    q_item;

  assign cfg_ready = 1'b1;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r  <= 48'd0;
      plow_r  <= 64'd0;
      pmid_r  <= 64'd0;
      plast_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP:      temp_r  <= cfg_data[47:0];
        CFG_PRES_LOW:  plow_r  <= cfg_data;
        CFG_PRES_MID:  pmid_r  <= cfg_data;
        CFG_PRES_LAST: plast_r <= cfg_data[15:0];
        default:       plast_r <= plast_r;
      endcase
    end
  end

  assign coeff.t1 = temp_r[15:0];
  assign coeff.t2 = temp_r[31:16];
  assign coeff.t3 = temp_r[47:32];
  assign coeff.p1 = plow_r[15:0];
  assign coeff.p2 = plow_r[31:16];
  assign coeff.p3 = plow_r[47:32];
  assign coeff.p4 = plow_r[63:48];
  assign coeff.p5 = pmid_r[15:0];
  assign coeff.p6 = pmid_r[31:16];
  assign coeff.p7 = pmid_r[47:32];
  assign coeff.p8 = pmid_r[63:48];
  assign coeff.p9 = plast_r;

  ptc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coeff     (coeff),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
